// ===== sv/mlfc_pkg.sv =====
// mlfc_pkg: widths, command codes and shared structs of the multi-LED flash controller.
// No dependencies; imported by the interfaces, the channel module, the top level and the checker.
package mlfc_pkg;

    localparam int FUNC_W           = 2;
    localparam int CHAN_W           = 3;
    localparam int CNT_W            = 32;
    localparam int PIN_W            = 5;
    localparam int NUM_CHANNELS_DEF = 5;

    localparam logic [PIN_W-1:0] PRESENT_RESET = '1;

    // command codes; the fourth code is a no-op
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FLASH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAN_W-1:0] channel;
        logic              level;
        logic              check_count;
        logic [CNT_W-1:0]  expected_count;
        logic [CNT_W-1:0]  flash_duration;
        logic [CNT_W-1:0]  flash_interval;
    } cmd_t;

    // decoded command broadcast to every channel, already qualified by the pipeline advance
    typedef struct packed {
        logic             is_set;
        logic             is_flash;
        logic             is_tick;
        logic             level;
        logic             check_count;
        logic [CNT_W-1:0] expected_count;
        logic [CNT_W-1:0] flash_duration;
        logic [CNT_W-1:0] flash_interval;
    } chan_cmd_t;

    // post-update view of one channel
    typedef struct packed {
        logic             pin;
        logic             flashing;
        logic [CNT_W-1:0] count_result;
    } chan_stat_t;

endpackage

// ===== sv/mlfc_if.sv =====
// mlfc_if: valid/ready channel interfaces for commands, results and the presence register.
// Depends on mlfc_pkg.
interface mlfc_cmd_if;
    import mlfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAN_W-1:0] channel;
    logic              level;
    logic              check_count;
    logic [CNT_W-1:0]  expected_count;
    logic [CNT_W-1:0]  flash_duration;
    logic [CNT_W-1:0]  flash_interval;

    modport source (output valid, func, channel, level, check_count, expected_count,
                    flash_duration, flash_interval, input ready);
    modport sink   (input valid, func, channel, level, check_count, expected_count,
                    flash_duration, flash_interval, output ready);
endinterface

interface mlfc_rsp_if;
    import mlfc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_result;
    logic [PIN_W-1:0] pin_levels;
    logic [PIN_W-1:0] flashing_mask;

    modport source (output valid, count_result, pin_levels, flashing_mask, input ready);
    modport sink   (input valid, count_result, pin_levels, flashing_mask, output ready);
endinterface

interface mlfc_cfg_if;
    import mlfc_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/mlfc_chan.sv =====
// mlfc_chan: state record of one LED channel (level, flash timer, change count).
// Depends on mlfc_pkg; instantiated once per channel by the top level.
module mlfc_chan
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mlfc_pkg::chan_cmd_t    cmd,
    input  logic                   sel,
    input  logic                   present,
    output mlfc_pkg::chan_stat_t   stat
);
    import mlfc_pkg::*;

    logic             steady_reg,    steady_next;
    logic             flashing_reg,  flashing_next;
    logic             pin_reg,       pin_next;
    logic             armed_reg,     armed_next;
    logic [CNT_W-1:0] remaining_reg, remaining_next;
    logic [CNT_W-1:0] interval_reg,  interval_next;
    logic [CNT_W-1:0] countdown_reg, countdown_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] result;
    logic             mismatch;

    assign count_inc = count_reg + CNT_W'(1);
    assign mismatch  = cmd.check_count && (cmd.expected_count != count_reg);

    always_comb
    begin
        steady_next    = steady_reg;
        flashing_next  = flashing_reg;
        pin_next       = pin_reg;
        armed_next     = armed_reg;
        remaining_next = remaining_reg;
        interval_next  = interval_reg;
        countdown_next = countdown_reg;
        count_next     = count_reg;
        result         = '0;

        if (cmd.is_set && sel)
        begin
            if (mismatch)
            begin
                result = count_reg;
            end
            else
            begin
                steady_next = cmd.level;
                if (!flashing_reg && present)
                begin
                    pin_next = cmd.level;
                end
                if (cmd.check_count)
                begin
                    result = cmd.expected_count;
                end
                else
                begin
                    count_next = count_inc;
                    result     = count_inc;
                end
            end
        end
        else if (cmd.is_flash && sel)
        begin
            flashing_next  = 1'b1;
            remaining_next = cmd.flash_duration;
            interval_next  = cmd.flash_interval;
            if (present)
            begin
                countdown_next = cmd.flash_interval;
                armed_next     = 1'b1;
            end
        end
        else if (cmd.is_tick && armed_reg)
        begin
            if (countdown_reg <= CNT_W'(1))
            begin
                // timer expiry
                armed_next = 1'b0;
                if (flashing_reg)
                begin
                    if (interval_reg > remaining_reg)
                    begin
                        // flash over: back to steady level
                        if (present)
                        begin
                            pin_next = steady_reg;
                        end
                        interval_next  = '0;
                        remaining_next = '0;
                        flashing_next  = 1'b0;
                    end
                    else
                    begin
                        if (present)
                        begin
                            pin_next       = !pin_reg;
                            countdown_next = interval_reg;
                            armed_next     = 1'b1;
                        end
                        remaining_next = remaining_reg - interval_reg;
                    end
                end
                else if (present)
                begin
                    pin_next = steady_reg;
                end
            end
            else
            begin
                countdown_next = countdown_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steady_reg    <= 1'b0;
            flashing_reg  <= 1'b0;
            pin_reg       <= 1'b0;
            armed_reg     <= 1'b0;
            remaining_reg <= '0;
            interval_reg  <= '0;
            countdown_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            steady_reg    <= steady_next;
            flashing_reg  <= flashing_next;
            pin_reg       <= pin_next;
            armed_reg     <= armed_next;
            remaining_reg <= remaining_next;
            interval_reg  <= interval_next;
            countdown_reg <= countdown_next;
            count_reg     <= count_next;
        end
    end

    assign stat.pin          = pin_next;
    assign stat.flashing     = flashing_next;
    assign stat.count_result = result;

endmodule

// ===== sv/multi_led_flash_controller.sv =====
// Multi-LED flash controller. Takes one command transaction per cycle on cmd (set level,
// start flash, timer tick) while rsp.ready is high and returns exactly one result
// transaction per command on rsp, in order. A command passes the input register, where
// every channel record is updated in parallel, then the result register. Sustained rate
// is one command per clock with rsp.ready high; it rests on the combinational update of
// the channel records (one 32-bit compare and subtract per channel). A held result lets
// an empty input register take the next command; a full one then stalls cmd. The presence
// mask is written through cfg (always ready) and should only change while no command is in
// flight; reset value is all channels present. Channels at index five and above are never
// present, and only channels zero to four appear on pin_levels and flashing_mask.
// Depends on mlfc_pkg, mlfc_if and mlfc_chan.
module multi_led_flash_controller
#(
    parameter int NUM_CHANNELS = mlfc_pkg::NUM_CHANNELS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    mlfc_cmd_if.sink   cmd,
    mlfc_rsp_if.source rsp,
    mlfc_cfg_if.sink   cfg
);
    import mlfc_pkg::*;

    // presence register
    logic [PIN_W-1:0] present_reg;

    // input stage
    logic             in_valid_reg;
    cmd_t             in_reg;

    // result stage
    logic             out_valid_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic [PIN_W-1:0] out_pins_reg;
    logic [PIN_W-1:0] out_flash_reg;

    logic             advance;     // input stage moves into result stage
    logic             cmd_take;    // command transaction on cmd
    chan_cmd_t        ccmd;
    logic [NUM_CHANNELS-1:0] sel;
    logic [NUM_CHANNELS-1:0] present;
    chan_stat_t       stat [NUM_CHANNELS];
    logic [CNT_W-1:0] count_any;
    logic [PIN_W-1:0] pins_any;
    logic [PIN_W-1:0] flash_any;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= PRESENT_RESET;
        end
        else if (cfg.valid)
        begin
            present_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_reg.func           <= cmd.func;
            in_reg.channel        <= cmd.channel;
            in_reg.level          <= cmd.level;
            in_reg.check_count    <= cmd.check_count;
            in_reg.expected_count <= cmd.expected_count;
            in_reg.flash_duration <= cmd.flash_duration;
            in_reg.flash_interval <= cmd.flash_interval;
        end
    end

    // command decode, gated so channel state only moves when the item advances
    assign ccmd.is_set         = advance && (in_reg.func == FUNC_SET);
    assign ccmd.is_flash       = advance && (in_reg.func == FUNC_FLASH);
    assign ccmd.is_tick        = advance && (in_reg.func == FUNC_TICK);
    assign ccmd.level          = in_reg.level;
    assign ccmd.check_count    = in_reg.check_count;
    assign ccmd.expected_count = in_reg.expected_count;
    assign ccmd.flash_duration = in_reg.flash_duration;
    assign ccmd.flash_interval = in_reg.flash_interval;

    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chan
        // wide compare so channel numbers beyond the field never alias
        assign sel[c] = (32'(in_reg.channel) == 32'(c));

        if (c < PIN_W)
        begin : g_pres
            assign present[c] = present_reg[c];
        end
        else
        begin : g_abs
            assign present[c] = 1'b0;
        end

        mlfc_chan u_chan
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (ccmd),
            .sel     (sel[c]),
            .present (present[c]),
            .stat    (stat[c])
        );
    end

    // only the addressed channel returns a nonzero count
    always_comb
    begin
        count_any = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            count_any = count_any | stat[c].count_result;
        end
    end

    for (genvar b = 0; b < PIN_W; b++)
    begin : g_view
        if (b < NUM_CHANNELS)
        begin : g_live
            assign pins_any[b]  = stat[b].pin;
            assign flash_any[b] = stat[b].flashing;
        end
        else
        begin : g_none
            assign pins_any[b]  = 1'b0;
            assign flash_any[b] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_count_reg <= count_any;
            out_pins_reg  <= pins_any;
            out_flash_reg <= flash_any;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.count_result  = out_count_reg;
    assign rsp.pin_levels    = out_pins_reg;
    assign rsp.flashing_mask = out_flash_reg;

endmodule

// ===== sv/mlfc_checker.sv =====
// mlfc_checker: port-level assertions for the multi-LED flash controller, plus its bind.
// Depends on mlfc_pkg; attaches to multi_led_flash_controller.
module mlfc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic [mlfc_pkg::FUNC_W-1:0] cmd_func,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [mlfc_pkg::CNT_W-1:0]  rsp_count_result,
    input logic [mlfc_pkg::PIN_W-1:0]  rsp_pin_levels,
    input logic [mlfc_pkg::PIN_W-1:0]  rsp_flashing_mask
);
    import mlfc_pkg::*;

    // a stalled result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_result)
            && $stable(rsp_pin_levels) && $stable(rsp_flashing_mask))
        else $error("result payload changed while stalled");

    // accepted command passes the input register and reaches the result register with output open
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) ##1 rsp_ready |=> rsp_valid)
        else $error("accepted command did not produce a result in time");

    // flash, tick and no-op commands return a zero count
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd_func != FUNC_SET) ##1 rsp_ready
            |=> rsp_count_result == '0)
        else $error("non-set command returned a nonzero count");

    // input stage never blocks while it is empty-equivalent: after a result drains, cmd is open
    a_cmd_open: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid && rsp_ready |=> cmd_ready)
        else $error("command port blocked with nothing pending");

endmodule

bind multi_led_flash_controller mlfc_checker u_mlfc_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .cmd_func          (cmd.func),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_count_result  (rsp.count_result),
    .rsp_pin_levels    (rsp.pin_levels),
    .rsp_flashing_mask (rsp.flashing_mask)
);

// ===== bench/led_flash_sb_pkg.sv =====
`timescale 1ns / 1ps
// led_flash_sb_pkg: channel-state predictor and result scoreboard for the LED flash bench.
// Depends on mlfc_pkg for the command struct, widths and command codes.
package led_flash_sb_pkg;
    import mlfc_pkg::*;

    localparam int NCH = NUM_CHANNELS_DEF;
    // the unused command code, a no-op
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CNT_W-1:0] count_result;
        logic [PIN_W-1:0] pin_levels;
        logic [PIN_W-1:0] flashing_mask;
    } led_status_t;

    class led_flash_scoreboard;
        bit               steady   [NCH];
        bit               flashing [NCH];
        bit               pin      [NCH];
        bit               armed    [NCH];
        bit [CNT_W-1:0]   remaining[NCH];
        bit [CNT_W-1:0]   interval [NCH];
        bit [CNT_W-1:0]   countdown[NCH];
        bit [CNT_W-1:0]   changes  [NCH];
        bit [PIN_W-1:0]   present;
        led_status_t      status_q[$];

        int errors;
        int n_checked;
        int n_set;
        int n_flash;
        int n_tick;
        int n_ignored;
        int n_flash_end;
        int n_settings;

        function new();
            foreach (steady[k])
            begin
                steady[k]    = 1'b0;
                flashing[k]  = 1'b0;
                pin[k]       = 1'b0;
                armed[k]     = 1'b0;
                remaining[k] = '0;
                interval[k]  = '0;
                countdown[k] = '0;
                changes[k]   = '0;
            end
            present = PRESENT_RESET;
        endfunction

        function void set_present(bit [PIN_W-1:0] mask);
            present = mask;
            n_settings++;
        endfunction

        function bit [CNT_W-1:0] count_of(int ch);
            return (ch < NCH) ? changes[ch] : $urandom;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endfunction

        // apply one accepted command transaction and queue the status it must produce
        function void note_command(cmd_t c);
            led_status_t want;
            int          ch;
            bit          pres;
            want = '0;
            ch   = c.channel;
            if (c.func == FUNC_SET && ch < NCH)
            begin
                n_set++;
                if (c.check_count && c.expected_count != changes[ch])
                    want.count_result = changes[ch];
                else
                begin
                    steady[ch] = c.level;
                    if (!flashing[ch] && ch < PIN_W && present[ch])
                        pin[ch] = c.level;
                    if (c.check_count)
                        want.count_result = c.expected_count;
                    else
                    begin
                        changes[ch]++;
                        want.count_result = changes[ch];
                    end
                end
            end
            else if (c.func == FUNC_FLASH && ch < NCH)
            begin
                n_flash++;
                flashing[ch]  = 1'b1;
                remaining[ch] = c.flash_duration;
                interval[ch]  = c.flash_interval;
                if (ch < PIN_W && present[ch])
                begin
                    countdown[ch] = c.flash_interval;
                    armed[ch]     = 1'b1;
                end
            end
            else if (c.func == FUNC_TICK)
            begin
                n_tick++;
                for (int k = 0; k < NCH; k++)
                begin
                    pres = (k < PIN_W) && present[k];
                    if (!armed[k])
                        continue;
                    if (countdown[k] > 1)
                    begin
                        countdown[k]--;
                        continue;
                    end
                    armed[k] = 1'b0;
                    if (flashing[k])
                    begin
                        if (interval[k] > remaining[k])
                        begin
                            // flash over: back to the steady level
                            if (pres)
                                pin[k] = steady[k];
                            interval[k]  = '0;
                            remaining[k] = '0;
                            flashing[k]  = 1'b0;
                            n_flash_end++;
                        end
                        else
                        begin
                            if (pres)
                                pin[k] = !pin[k];
                            remaining[k] -= interval[k];
                            if (pres)
                            begin
                                countdown[k] = interval[k];
                                armed[k]     = 1'b1;
                            end
                        end
                    end
                    else if (pres)
                        pin[k] = steady[k];
                end
            end
            else
                n_ignored++;

            for (int k = 0; k < NCH && k < PIN_W; k++)
            begin
                want.pin_levels[k]    = pin[k];
                want.flashing_mask[k] = flashing[k];
            end
            status_q.push_back(want);
        endfunction

        function void check_result(led_status_t got);
            led_status_t want;
            if (status_q.size() == 0)
            begin
                flag($sformatf("result with nothing outstanding: count %0h pins %b flash %b",
                               got.count_result, got.pin_levels, got.flashing_mask));
                return;
            end
            want = status_q.pop_front();
            n_checked++;
            if (got !== want)
                flag($sformatf("result %0d: count exp %0h got %0h, pins exp %b got %b, %s%b got %b",
                               n_checked, want.count_result, got.count_result,
                               want.pin_levels, got.pin_levels, "flash exp ",
                               want.flashing_mask, got.flashing_mask));
        endfunction
    endclass

endpackage

// ===== bench/multi_led_flash_controller_tb.sv =====
`timescale 1ns / 1ps
// multi_led_flash_controller_tb: drives set/flash/tick commands and presence writes, checks results.
// Depends on mlfc_pkg, mlfc_if, led_flash_sb_pkg and the multi_led_flash_controller RTL.
module multi_led_flash_controller_tb;
    import mlfc_pkg::*;
    import led_flash_sb_pkg::*;

    localparam int ITEMS_PER_PHASE = 325;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int STALL_LIMIT     = 3000;  // well above the hold-off plus gaps
    localparam int TAIL_CYCLES     = 8;     // drain margin after the last result

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mlfc_cmd_if cmd_bus();
    mlfc_rsp_if rsp_bus();
    mlfc_cfg_if cfg_bus();

    multi_led_flash_controller dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    led_flash_scoreboard sb = new();

    bit idle_on   = 1'b1;   // random idling on both sides
    int hold_left = 0;      // receiver hold-off, counted down by the receiver process
    int stall_cnt = 0;

    // ---------------------------------------------------------------
    // Reset and initial values of the command and presence inputs
    // ---------------------------------------------------------------
    initial
    begin
        rst_n                  <= 1'b0;
        cmd_bus.valid          <= 1'b0;
        cmd_bus.func           <= FUNC_NOP;
        cmd_bus.channel        <= '0;
        cmd_bus.level          <= 1'b0;
        cmd_bus.check_count    <= 1'b0;
        cmd_bus.expected_count <= '0;
        cmd_bus.flash_duration <= '0;
        cmd_bus.flash_interval <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.data           <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Result side: random back-pressure, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (idle_on)
                rsp_bus.ready <= ($urandom_range(99) >= 20);
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // every result transaction is checked against the oldest expected status
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_result({rsp_bus.count_result, rsp_bus.pin_levels, rsp_bus.flashing_mask});
    end

    // watchdog: a long run of cycles with no transaction on any port means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                stall_cnt <= 0;
            else if (stall_cnt >= STALL_LIMIT)
            begin
                $display("[%0t] timeout: no transaction for %0d cycles, %0d results outstanding",
                         $time, stall_cnt, sb.pending());
                $display("Simulation FAILED");
                $finish;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------
    function automatic cmd_t mk(logic [FUNC_W-1:0] func, int ch, bit lvl, bit chk,
                                bit [CNT_W-1:0] exp_cnt, bit [CNT_W-1:0] dur,
                                bit [CNT_W-1:0] ivl);
        cmd_t c;
        c.func           = func;
        c.channel        = ch[CHAN_W-1:0];
        c.level          = lvl;
        c.check_count    = chk;
        c.expected_count = exp_cnt;
        c.flash_duration = dur;
        c.flash_interval = ivl;
        return c;
    endfunction

    // Offer one command until accepted, then maybe leave a gap. valid is only lowered
    // for a gap, so back-to-back transactions never see a low/high pair in one step.
    task automatic send_cmd(cmd_t c);
        cmd_bus.valid          <= 1'b1;
        cmd_bus.func           <= c.func;
        cmd_bus.channel        <= c.channel;
        cmd_bus.level          <= c.level;
        cmd_bus.check_count    <= c.check_count;
        cmd_bus.expected_count <= c.expected_count;
        cmd_bus.flash_duration <= c.flash_duration;
        cmd_bus.flash_interval <= c.flash_interval;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        sb.note_command(c);
        if (idle_on && $urandom_range(99) < 20)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // sender pause: stop offering and wait for every outstanding result
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // presence register write; only called with nothing in flight
    task automatic write_present(bit [PIN_W-1:0] mask);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= mask;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sb.set_present(mask);
    endtask

    // Random command. Ticks are the most common kind so flashes run to completion, short flash
    // timing so endings happen often, and guarded sets that often carry the right count.
    function automatic cmd_t random_cmd();
        cmd_t           c;
        int             pick;
        int             ch;
        bit [CNT_W-1:0] cur;
        c.level          = 1'($urandom);
        c.check_count    = 1'($urandom);
        c.expected_count = $urandom;
        c.flash_duration = $urandom;
        c.flash_interval = $urandom;
        ch               = ($urandom_range(99) < 7) ? $urandom_range(NCH, 7)
                                                    : $urandom_range(0, NCH - 1);
        c.channel        = ch[CHAN_W-1:0];
        pick             = $urandom_range(99);
        if (pick < 45)
            c.func = FUNC_TICK;
        else if (pick < 72)
        begin
            c.func = FUNC_SET;
            cur    = sb.count_of(ch);
            case ($urandom_range(3))
                0, 1: c.expected_count = cur;
                2:    c.expected_count = $urandom_range(1) ? cur + 1 : cur - 1;
                default: ;
            endcase
        end
        else if (pick < 96)
        begin
            c.func = FUNC_FLASH;
            case ($urandom_range(9))
                0: ;    // full-range timing, rarely expires
                1:
                begin
                    c.flash_interval = $urandom_range(0, 3);
                    c.flash_duration = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                end
                default:
                begin
                    c.flash_interval = $urandom_range(0, 6);
                    c.flash_duration = $urandom_range(0, 30);
                end
            endcase
        end
        else
            c.func = FUNC_NOP;
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        bit [PIN_W-1:0] masks [5];
        masks = '{5'b11111, 5'b00000, 5'b10101, 5'b01010, 5'b11111};
        masks[3] = PIN_W'($urandom_range(1, 30));

        do
            @(posedge clk);
        while (rst_n !== 1'b1);

        write_present(PRESENT_RESET);

        // directed: guarded sets, out-of-range channel, no-op, flash ending and restart,
        // zero interval, full-range timing, set while flashing
        send_cmd(mk(FUNC_SET,   0, 1, 0, 0, 0, 0));               // count 1
        send_cmd(mk(FUNC_SET,   0, 0, 1, 1, 0, 0));               // matching count
        send_cmd(mk(FUNC_SET,   0, 1, 1, 32'hFFFF_FFFF, 0, 0));   // stale count, no change
        send_cmd(mk(FUNC_SET,   4, 1, 1, 0, 0, 0));               // count 0 matches
        send_cmd(mk(FUNC_SET,   7, 1, 0, 32'hFFFF_FFFF, 0, 0));   // channel out of range
        send_cmd(mk(FUNC_FLASH, 5, 1, 1, 0, 4, 1));               // channel out of range
        send_cmd(mk(FUNC_NOP,   7, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(mk(FUNC_FLASH, 1, 0, 0, 0, 4, 1));
        send_cmd(mk(FUNC_SET,   1, 1, 0, 0, 0, 0));               // set while flashing
        send_cmd(mk(FUNC_FLASH, 2, 0, 0, 0, 0, 0));               // zero interval
        send_cmd(mk(FUNC_FLASH, 3, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        repeat (6)
            send_cmd(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));            // ch1 ends its flash
        send_cmd(mk(FUNC_FLASH, 3, 0, 0, 0, 0, 2));               // restart, ends on expiry
        send_cmd(mk(FUNC_TICK,  0, 0, 0, 0, 0, 0));
        send_cmd(mk(FUNC_TICK,  0, 0, 0, 0, 0, 0));
        send_cmd(mk(FUNC_SET,   2, 0, 0, 0, 0, 0));
        send_cmd(mk(FUNC_FLASH, 2, 1, 0, 0, 1, 5));
        send_cmd(mk(FUNC_TICK,  7, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain();

        // random phases, one presence setting each; flashes armed in one phase carry
        // over into the next so a presence change lands on running timers
        for (int p = 0; p < 5; p++)
        begin
            write_present(masks[p]);
            idle_on = (p != 2);     // phase 2 runs with no idling on either side
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 3 && i == 20)
                    hold_left = HOLD_CYCLES;   // sender keeps offering while results back up
                send_cmd(random_cmd());
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.flag($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Ran %0d commands: %0d set, %0d flash, %0d tick, %0d ignored; %0d flashes ended",
                 sb.n_set + sb.n_flash + sb.n_tick + sb.n_ignored, sb.n_set, sb.n_flash,
                 sb.n_tick, sb.n_ignored, sb.n_flash_end);
        $display("Checked %0d results over %0d presence settings, %0d mismatches",
                 sb.n_checked, sb.n_settings, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
